// ===== design/vat_pkg.sv =====
// vat_pkg: shared types, constants and helper functions of the vertex
// affine transform block. Used by every module of the block; no dependencies.
`default_nettype none

package vat_pkg;

	// Coordinate and fixed-point formats
	localparam int COORD_COUNT = 3;
	localparam int COORD_SEL_W = 2;
	localparam int COORD_W = 32;
	localparam int FRAC_BITS = 16;
	localparam int ROUND_HALF = 32768;
	localparam int SAT_IN_W = 2 * COORD_W;

	// Coordinate positions inside an item
	localparam logic [COORD_SEL_W-1:0] COORD_X = 2'd0;
	localparam logic [COORD_SEL_W-1:0] COORD_Y = 2'd1;
	localparam logic [COORD_SEL_W-1:0] COORD_Z = 2'd2;

	// Trig and CORDIC formats
	localparam int TRIG_W = 18;
	localparam int ANGLE_W = 19;
	localparam int CORDIC_W = 20;
	localparam int ATAN_IDX_W = 5;
	localparam int ANGLE_PI = 205887;
	localparam int ANGLE_HALF_PI = 102944;
	localparam int CORDIC_GAIN = 39797;
	localparam int TRIG_ONE = 65536;
	localparam int SCALE_ONE = 65536;

	// Defaults for top-level parameters
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_OFFSET_X = 3'd1,
		REG_OFFSET_Y = 3'd2,
		REG_OFFSET_Z = 3'd3,
		REG_ANGLE    = 3'd4,
		REG_SCALE    = 3'd5
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TRANSLATE = 3'd0,
		MODE_ROT_X     = 3'd1,
		MODE_ROT_Y     = 3'd2,
		MODE_ROT_Z     = 3'd3,
		MODE_SCALE     = 3'd4
	} mode_t;

	// Per-coordinate operation chosen by the front part
	typedef enum logic [1:0] {
		LANE_PASS = 2'd0,
		LANE_ADD  = 2'd1,
		LANE_MAC  = 2'd2
	} lane_op_t;

	typedef struct packed {
		lane_op_t                 op;
		logic                     scale;  // product A uses scale factor, B is zero
		logic [COORD_SEL_W-1:0]   b_sel;  // coordinate that feeds the sine product
		logic                     b_sub;  // subtract the sine product
	} lane_ctrl_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic                      last_vertex;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] result_x;
		logic signed [COORD_W-1:0] result_y;
		logic signed [COORD_W-1:0] result_z;
		logic                      result_last;
	} out_item_t;

	typedef struct packed {
		lane_ctrl_t [COORD_COUNT-1:0] lane;
		in_item_t                     item;
	} q_entry_t;

	// Live configuration as seen by front and back
	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic signed [COORD_W-1:0] offset_x;
		logic signed [COORD_W-1:0] offset_y;
		logic signed [COORD_W-1:0] offset_z;
		logic signed [COORD_W-1:0] scale_factor;
		logic                      angle_nz;
		logic                      scale_nz;
		logic signed [TRIG_W-1:0]  cosine_value;
		logic signed [TRIG_W-1:0]  sine_value;
	} cfg_t;

	// Saturate a wide signed value to a coordinate
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [SAT_IN_W-1:0] v
	);
		logic signed [COORD_W-1:0] r;
		if (&v[SAT_IN_W-1:COORD_W-1] || ~|v[SAT_IN_W-1:COORD_W-1]) begin
			r = v[COORD_W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Saturate a CORDIC value to the trig format
	function automatic logic signed [TRIG_W-1:0] sat_trig(
		input logic signed [CORDIC_W-1:0] v
	);
		logic signed [TRIG_W-1:0] r;
		if (&v[CORDIC_W-1:TRIG_W-1] || ~|v[CORDIC_W-1:TRIG_W-1]) begin
			r = v[TRIG_W-1:0];
		end else if (v[CORDIC_W-1]) begin
			r = {1'b1, {(TRIG_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(TRIG_W-1){1'b1}}};
		end
		return r;
	endfunction

	// atan(2^-i) in Q16, rounded
	function automatic logic signed [CORDIC_W-1:0] atan_q16(
		input logic [ATAN_IDX_W-1:0] idx
	);
		logic signed [CORDIC_W-1:0] r;
		case (idx)
			5'd0:    r = CORDIC_W'(51472);
			5'd1:    r = CORDIC_W'(30386);
			5'd2:    r = CORDIC_W'(16055);
			5'd3:    r = CORDIC_W'(8150);
			5'd4:    r = CORDIC_W'(4091);
			5'd5:    r = CORDIC_W'(2047);
			5'd6:    r = CORDIC_W'(1024);
			5'd7:    r = CORDIC_W'(512);
			5'd8:    r = CORDIC_W'(256);
			5'd9:    r = CORDIC_W'(128);
			5'd10:   r = CORDIC_W'(64);
			5'd11:   r = CORDIC_W'(32);
			5'd12:   r = CORDIC_W'(16);
			5'd13:   r = CORDIC_W'(8);
			5'd14:   r = CORDIC_W'(4);
			5'd15:   r = CORDIC_W'(2);
			5'd16:   r = CORDIC_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/vat_cordic.sv =====
// vat_cordic: iterative CORDIC that turns the rotation angle into cosine and
// sine, one step per cycle, and holds them. Depends on vat_pkg.
`default_nettype none

module vat_cordic #(
	parameter int STEPS = vat_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic signed [vat_pkg::ANGLE_W-1:0]     angle,
	output logic                                        busy,
	output logic signed [vat_pkg::TRIG_W-1:0]           cosine_value,
	output logic signed [vat_pkg::TRIG_W-1:0]           sine_value
);

	localparam int CNT_W = $clog2(STEPS);
	localparam int CW = vat_pkg::CORDIC_W;

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   flip_q;
	logic signed [CW-1:0]   x_q, y_q, z_q;
	logic signed [vat_pkg::TRIG_W-1:0] cos_q, sin_q;

	logic signed [CW-1:0]   a_ext, a_clamp, z_init;
	logic                   flip_init;
	logic signed [CW-1:0]   nx, ny, nz, atan_v, fx, fy;
	logic                   last_step;

	// Clamp to plus or minus pi, then fold into plus or minus pi/2
	always_comb begin
		a_ext = CW'(angle);
		if (a_ext > CW'(vat_pkg::ANGLE_PI)) begin
			a_clamp = CW'(vat_pkg::ANGLE_PI);
		end else if (a_ext < -CW'(vat_pkg::ANGLE_PI)) begin
			a_clamp = -CW'(vat_pkg::ANGLE_PI);
		end else begin
			a_clamp = a_ext;
		end
		flip_init = 1'b1;
		if (a_clamp > CW'(vat_pkg::ANGLE_HALF_PI)) begin
			z_init = a_clamp - CW'(vat_pkg::ANGLE_PI);
		end else if (a_clamp < -CW'(vat_pkg::ANGLE_HALF_PI)) begin
			z_init = a_clamp + CW'(vat_pkg::ANGLE_PI);
		end else begin
			z_init = a_clamp;
			flip_init = 1'b0;
		end
	end

	// One micro-rotation
	always_comb begin
		atan_v = vat_pkg::atan_q16(vat_pkg::ATAN_IDX_W'(cnt_q));
		if (!z_q[CW-1]) begin
			nx = x_q - (y_q >>> cnt_q);
			ny = y_q + (x_q >>> cnt_q);
			nz = z_q - atan_v;
		end else begin
			nx = x_q + (y_q >>> cnt_q);
			ny = y_q - (x_q >>> cnt_q);
			nz = z_q + atan_v;
		end
		fx = flip_q ? -nx : nx;
		fy = flip_q ? -ny : ny;
		last_step = (cnt_q == CNT_W'(STEPS - 1));
	end

	// Control: busy flag and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			busy_q <= !last_step;
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	// Held trig results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= vat_pkg::TRIG_W'(vat_pkg::TRIG_ONE);
			sin_q <= '0;
		end else if (busy_q && last_step && !start) begin
			cos_q <= vat_pkg::sat_trig(fx);
			sin_q <= vat_pkg::sat_trig(fy);
		end
	end

	// Iteration datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CW'(vat_pkg::CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	assign busy         = busy_q;
	assign cosine_value = cos_q;
	assign sine_value   = sin_q;

endmodule

`default_nettype wire

// ===== design/vat_front.sv =====
// vat_front: accepts vertex items and classifies them into per-coordinate
// operations for the back part. Depends on vat_pkg.
`default_nettype none

module vat_front (
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire vat_pkg::in_item_t in_item,
	input  wire vat_pkg::cfg_t     cfg,
	input  wire logic              trig_busy,
	input  wire logic              queue_full,
	output logic                   push,
	output vat_pkg::q_entry_t      push_entry
);

	vat_pkg::lane_ctrl_t [vat_pkg::COORD_COUNT-1:0] lane;

	// Accept while the queue has room and trig values are settled
	assign in_ready = !queue_full && !trig_busy;
	assign push     = in_valid && in_ready;

	// Rotations: lane A term is own coordinate times cosine, B term is the
	// partner coordinate times sine, added or subtracted
	always_comb begin
		for (int j = 0; j < vat_pkg::COORD_COUNT; j++) begin
			lane[j].op    = vat_pkg::LANE_PASS;
			lane[j].scale = 1'b0;
			lane[j].b_sel = vat_pkg::COORD_X;
			lane[j].b_sub = 1'b0;
		end
		unique case (cfg.mode)
			vat_pkg::MODE_TRANSLATE: begin
				for (int j = 0; j < vat_pkg::COORD_COUNT; j++) begin
					lane[j].op = vat_pkg::LANE_ADD;
				end
			end
			vat_pkg::MODE_ROT_X: begin
				if (cfg.angle_nz) begin
					lane[vat_pkg::COORD_Y].op    = vat_pkg::LANE_MAC;
					lane[vat_pkg::COORD_Y].b_sel = vat_pkg::COORD_Z;
					lane[vat_pkg::COORD_Y].b_sub = 1'b1;
					lane[vat_pkg::COORD_Z].op    = vat_pkg::LANE_MAC;
					lane[vat_pkg::COORD_Z].b_sel = vat_pkg::COORD_Y;
				end
			end
			vat_pkg::MODE_ROT_Y: begin
				if (cfg.angle_nz) begin
					lane[vat_pkg::COORD_X].op    = vat_pkg::LANE_MAC;
					lane[vat_pkg::COORD_X].b_sel = vat_pkg::COORD_Z;
					lane[vat_pkg::COORD_Z].op    = vat_pkg::LANE_MAC;
					lane[vat_pkg::COORD_Z].b_sel = vat_pkg::COORD_X;
					lane[vat_pkg::COORD_Z].b_sub = 1'b1;
				end
			end
			vat_pkg::MODE_ROT_Z: begin
				if (cfg.angle_nz) begin
					lane[vat_pkg::COORD_X].op    = vat_pkg::LANE_MAC;
					lane[vat_pkg::COORD_X].b_sel = vat_pkg::COORD_Y;
					lane[vat_pkg::COORD_X].b_sub = 1'b1;
					lane[vat_pkg::COORD_Y].op    = vat_pkg::LANE_MAC;
					lane[vat_pkg::COORD_Y].b_sel = vat_pkg::COORD_X;
				end
			end
			vat_pkg::MODE_SCALE: begin
				if (cfg.scale_nz) begin
					for (int j = 0; j < vat_pkg::COORD_COUNT; j++) begin
						lane[j].op    = vat_pkg::LANE_MAC;
						lane[j].scale = 1'b1;
					end
				end
			end
			default: begin
				// unused mode codes pass the vertex through
			end
		endcase
	end

	// Queue entry: lane controls above the vertex item
	assign push_entry = {lane, in_item};

endmodule

`default_nettype wire

// ===== design/vat_queue.sv =====
// vat_queue: short FIFO of classified items between front and back.
// Depends on vat_pkg.
`default_nettype none

module vat_queue #(
	parameter int DEPTH = vat_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire vat_pkg::q_entry_t push_entry,
	output logic                   full,
	input  wire logic              pop,
	output logic                   entry_valid,
	output vat_pkg::q_entry_t      pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vat_pkg::q_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign full        = (count_q == CNT_W'(DEPTH));
	assign entry_valid = (count_q != '0);
	assign pop_entry   = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== design/vat_back.sv =====
// vat_back: two-stage datapath that carries out the classified operations:
// products in stage 1, add/round/saturate into the output register in
// stage 2. Depends on vat_pkg.
`default_nettype none

module vat_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              entry_valid,
	input  wire vat_pkg::q_entry_t entry,
	output logic                   entry_pop,
	input  wire vat_pkg::cfg_t     cfg,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output vat_pkg::out_item_t     out_item
);

	localparam int N    = vat_pkg::COORD_COUNT;
	localparam int CW   = vat_pkg::COORD_W;
	localparam int PA_W = vat_pkg::SAT_IN_W;
	localparam int PB_W = vat_pkg::COORD_W + vat_pkg::TRIG_W;

	logic signed [CW-1:0]   vin [N];
	logic signed [CW-1:0]   off [N];
	logic signed [CW-1:0]   va [N];
	logic signed [CW-1:0]   vb [N];
	logic signed [CW-1:0]   coef_a [N];
	logic signed [PA_W-1:0] prod_a [N];
	logic signed [PB_W-1:0] prod_b [N];

	logic                   vld_s1;
	logic signed [PA_W-1:0] prod_a_s1 [N];
	logic signed [PB_W-1:0] prod_b_s1 [N];
	logic signed [CW-1:0]   vin_s1 [N];
	vat_pkg::lane_ctrl_t    ctrl_s1 [N];
	logic                   last_s1;

	logic signed [PA_W-1:0] pb_ext [N];
	logic signed [PA_W-1:0] acc [N];
	logic signed [PA_W-1:0] rnd [N];
	logic signed [CW:0]     sum_add [N];
	logic signed [CW-1:0]   res [N];

	logic                   vld_s2;
	vat_pkg::out_item_t     item_s2;

	logic                   adv_s2, adv_s1;

	// Stall chain: output register frees stage 1, stage 1 frees the queue
	assign adv_s2    = !vld_s2 || out_ready;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign entry_pop = entry_valid && adv_s1;

	assign vin[vat_pkg::COORD_X] = entry.item.vertex_x;
	assign vin[vat_pkg::COORD_Y] = entry.item.vertex_y;
	assign vin[vat_pkg::COORD_Z] = entry.item.vertex_z;
	assign off[vat_pkg::COORD_X] = cfg.offset_x;
	assign off[vat_pkg::COORD_Y] = cfg.offset_y;
	assign off[vat_pkg::COORD_Z] = cfg.offset_z;

	// Stage 1 operand selection and products
	always_comb begin
		for (int j = 0; j < N; j++) begin
			va[j]     = vin[j];
			coef_a[j] = entry.lane[j].scale ? cfg.scale_factor : CW'(cfg.cosine_value);
			unique case (entry.lane[j].b_sel)
				vat_pkg::COORD_X: vb[j] = vin[vat_pkg::COORD_X];
				vat_pkg::COORD_Y: vb[j] = vin[vat_pkg::COORD_Y];
				default:          vb[j] = vin[vat_pkg::COORD_Z];
			endcase
			if (entry.lane[j].scale) begin
				vb[j] = '0;
			end
			prod_a[j] = va[j] * coef_a[j];
			prod_b[j] = vb[j] * cfg.sine_value;
		end
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_pop) begin
			for (int j = 0; j < N; j++) begin
				prod_a_s1[j] <= prod_a[j];
				prod_b_s1[j] <= prod_b[j];
				vin_s1[j]    <= vin[j];
				ctrl_s1[j]   <= entry.lane[j];
			end
			last_s1 <= entry.item.last_vertex;
		end
	end

	// Stage 2: combine, round, saturate
	always_comb begin
		for (int j = 0; j < N; j++) begin
			pb_ext[j]  = PA_W'(prod_b_s1[j]);
			acc[j]     = ctrl_s1[j].b_sub ? (prod_a_s1[j] - pb_ext[j])
			                              : (prod_a_s1[j] + pb_ext[j]);
			rnd[j]     = (acc[j] + PA_W'(vat_pkg::ROUND_HALF)) >>> vat_pkg::FRAC_BITS;
			sum_add[j] = (CW+1)'(vin_s1[j]) + (CW+1)'(off[j]);
			unique case (ctrl_s1[j].op)
				vat_pkg::LANE_ADD: res[j] = vat_pkg::sat_coord(PA_W'(sum_add[j]));
				vat_pkg::LANE_MAC: res[j] = vat_pkg::sat_coord(rnd[j]);
				default:           res[j] = vin_s1[j];
			endcase
		end
	end

	// Stage 2 is the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			item_s2.result_x    <= res[vat_pkg::COORD_X];
			item_s2.result_y    <= res[vat_pkg::COORD_Y];
			item_s2.result_z    <= res[vat_pkg::COORD_Z];
			item_s2.result_last <= last_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_item  = item_s2;

endmodule

`default_nettype wire

// ===== design/vertex_affine_transform.sv =====
// vertex_affine_transform: top level with configuration registers, CORDIC
// trig unit, front classifier, item queue and back datapath.
// Depends on vat_pkg, vat_cordic, vat_front, vat_queue, vat_back.
//
// Usage:
//   in channel  (in_valid/in_ready/in_item): one Q16.16 vertex per item.
//   out channel (out_valid/out_ready/out_item): one transformed vertex per
//     item, in input order, with result_last copied from last_vertex.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//     index 0 mode, 1-3 offsets, 4 angle, 5 scale; other indexes ignored.
//   Throughput: one vertex per cycle while no trig computation runs and the
//     receiver takes results. Items pass queue, product stage, output register.
//   A write of the angle starts the CORDIC, which runs CORDIC_STEPS
//     micro-rotations, one per cycle; during that time in_ready and
//     cfg_ready are low.
//   Reset: mode translate, offsets and angle zero, scale 1.0, cosine 1.0,
//     sine zero; queue and pipeline empty.
//   Receiver stall: the output register holds its item; stage 1 and the
//     QUEUE_DEPTH-entry queue keep filling, then in_ready drops.
`default_nettype none

module vertex_affine_transform #(
	parameter int CORDIC_STEPS = vat_pkg::CORDIC_STEPS_DEF,
	parameter int QUEUE_DEPTH  = vat_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire vat_pkg::in_item_t                 in_item,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output vat_pkg::out_item_t                     out_item,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [vat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vat_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = vat_pkg::COORD_W;

	logic [vat_pkg::MODE_W-1:0]          mode_q;
	logic signed [CW-1:0]                offset_x_q, offset_y_q, offset_z_q;
	logic signed [vat_pkg::ANGLE_W-1:0]  angle_q;
	logic signed [CW-1:0]                scale_q;

	logic                                cfg_we, trig_start, trig_busy;
	logic signed [vat_pkg::TRIG_W-1:0]   cos_v, sin_v;
	vat_pkg::cfg_t                       cfg;

	logic                                push, queue_full, pop, entry_valid;
	vat_pkg::q_entry_t                   push_entry, pop_entry;

	assign cfg_ready  = !trig_busy;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign trig_start = cfg_we && (cfg_index == vat_pkg::REG_ANGLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= vat_pkg::MODE_TRANSLATE;
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
			angle_q    <= '0;
			scale_q    <= CW'(vat_pkg::SCALE_ONE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				vat_pkg::REG_MODE:     mode_q     <= cfg_data[vat_pkg::MODE_W-1:0];
				vat_pkg::REG_OFFSET_X: offset_x_q <= cfg_data;
				vat_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data;
				vat_pkg::REG_OFFSET_Z: offset_z_q <= cfg_data;
				vat_pkg::REG_ANGLE:    angle_q    <= cfg_data[vat_pkg::ANGLE_W-1:0];
				vat_pkg::REG_SCALE:    scale_q    <= cfg_data;
				default: begin
					// write beyond the register list is dropped
				end
			endcase
		end
	end

	vat_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (trig_start),
		.angle       (cfg_data[vat_pkg::ANGLE_W-1:0]),
		.busy        (trig_busy),
		.cosine_value(cos_v),
		.sine_value  (sin_v)
	);

	// Configuration view shared by front and back
	always_comb begin
		cfg.mode         = mode_q;
		cfg.offset_x     = offset_x_q;
		cfg.offset_y     = offset_y_q;
		cfg.offset_z     = offset_z_q;
		cfg.scale_factor = scale_q;
		cfg.angle_nz     = (angle_q != '0);
		cfg.scale_nz     = (scale_q != '0);
		cfg.cosine_value = cos_v;
		cfg.sine_value   = sin_v;
	end

	vat_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg       (cfg),
		.trig_busy (trig_busy),
		.queue_full(queue_full),
		.push      (push),
		.push_entry(push_entry)
	);

	vat_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.entry_valid(entry_valid),
		.pop_entry  (pop_entry)
	);

	vat_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_valid(entry_valid),
		.entry      (pop_entry),
		.entry_pop  (pop),
		.cfg        (cfg),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire

// ===== design/vat_checker.sv =====
// vat_checker: port-level assertions for vertex_affine_transform, attached
// by the bind statement at the end. Depends on vat_pkg.
`default_nettype none

module vat_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire vat_pkg::in_item_t              in_item,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire vat_pkg::out_item_t             out_item,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready,
	input wire logic [vat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [vat_pkg::CFG_DATA_W-1:0] cfg_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("result changed or dropped while stalled");

	// A result only leaves after being taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without handshake");

	// Angle write starts trig computation, which blocks both channels
	a_angle_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == vat_pkg::REG_ANGLE)
		|=> (!in_ready && !cfg_ready))
		else $error("angle write did not hold off items");

	// No vertex is taken while trig values are being computed
	a_trig_gate: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> !in_ready)
		else $error("item accepted during trig computation");

endmodule

bind vertex_affine_transform vat_checker u_vat_checker (.*);

`default_nettype wire
